// ===== rtl/fsbp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsbp_pkg
// Shared types and constants for the framed status byte parser.
// ----------------------------------------------------------------------------
package fsbp_pkg;

  // Frame buffer depth and the derived width of the byte position counter.
  localparam int unsigned BUFFER_BYTES = 12;
  localparam int unsigned IDX_W        = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned CMP_W        = ((IDX_W > 4) ? IDX_W : 4) + 1;

  // Only frame positions 0 to 5 are ever read, so only those are kept.
  localparam int unsigned FIELD_BYTES  = 6;
  localparam int unsigned KEEP_BYTES   =
      (BUFFER_BYTES < FIELD_BYTES) ? BUFFER_BYTES : FIELD_BYTES;

  localparam logic [7:0] START_BYTE_RST   = 8'h21;
  localparam logic [7:0] END_BYTE_RST     = 8'h3B;
  localparam logic [7:0] TYPE_CODE_RST    = 8'hC0;
  localparam logic [3:0] FRAME_LENGTH_RST = 4'd7;

  typedef enum logic [1:0] {
    CFG_START_BYTE   = 2'd0,
    CFG_END_BYTE     = 2'd1,
    CFG_TYPE_CODE    = 2'd2,
    CFG_FRAME_LENGTH = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] end_byte;
    logic [7:0] type_code;
    logic [3:0] frame_length;
  } cfg_t;

  typedef struct packed {
    logic [7:0] direction;
    logic [7:0] gear;
    logic [4:0] flags;
    logic [7:0] battery_level;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/fsbp_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsbp_cfg_regs
// Configuration register file, written one register per transaction.
// ----------------------------------------------------------------------------
module fsbp_cfg_regs
  import fsbp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output      logic       cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i,
  output      cfg_t       cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_START_BYTE:   cfg_d.start_byte   = cfg_data_i;
        CFG_END_BYTE:     cfg_d.end_byte     = cfg_data_i;
        CFG_TYPE_CODE:    cfg_d.type_code    = cfg_data_i;
        CFG_FRAME_LENGTH: cfg_d.frame_length = cfg_data_i[3:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte   <= START_BYTE_RST;
      cfg_q.end_byte     <= END_BYTE_RST;
      cfg_q.type_code    <= TYPE_CODE_RST;
      cfg_q.frame_length <= FRAME_LENGTH_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/fsbp_frame_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsbp_frame_core
// Input register, frame tracking state and field extraction for one byte.
// ----------------------------------------------------------------------------
module fsbp_frame_core
  import fsbp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cfg_t       cfg_i,
  input  wire logic       in_valid_i,
  output      logic       in_ready_o,
  input  wire logic [7:0] rx_byte_i,
  output      logic       res_valid_o,
  input  wire logic       res_ready_i,
  output      result_t    res_o
);

  logic             in_valid_q, in_valid_d;
  logic [7:0]       byte_q;
  logic             receiving_q, receiving_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [3:0]       exp_q, exp_d;
  logic [7:0]       buf_q [KEEP_BYTES];
  logic [7:0]       buf_d [KEEP_BYTES];
  logic [7:0]       view  [FIELD_BYTES];
  logic             open_frame, close_frame, frame_ok, step;
  logic [CMP_W-1:0] idx_next;

  assign idx_next    = CMP_W'(idx_q) + CMP_W'(1);
  assign open_frame  = !receiving_q && (byte_q == cfg_i.start_byte);
  assign close_frame = receiving_q && (byte_q == cfg_i.end_byte)
                       && (idx_next == CMP_W'(exp_q));

  // Buffer as seen after the current byte is stored; unkept positions read zero.
  always_comb begin
    for (int i = 0; i < FIELD_BYTES; i++) begin
      if (i < KEEP_BYTES) begin
        view[i] = (idx_q == IDX_W'(i)) ? byte_q : buf_q[i];
      end else begin
        view[i] = 8'h00;
      end
    end
  end

  assign frame_ok    = close_frame && (view[0] == cfg_i.start_byte)
                       && (view[1] == cfg_i.type_code);
  assign res_valid_o = in_valid_q && frame_ok;
  assign step        = in_valid_q && (!frame_ok || res_ready_i);
  assign in_ready_o  = !in_valid_q || step;
  assign in_valid_d  = in_valid_i || (in_valid_q && !step);

  assign res_o.direction     = view[2];
  assign res_o.gear          = view[3];
  assign res_o.flags         = view[4][4:0];
  assign res_o.battery_level = view[5];

  always_comb begin
    receiving_d = receiving_q;
    idx_d       = idx_q;
    exp_d       = exp_q;
    for (int i = 0; i < KEEP_BYTES; i++) begin
      buf_d[i] = buf_q[i];
    end
    if (step) begin
      if (open_frame) begin
        receiving_d = 1'b1;
        idx_d       = IDX_W'(1);
        exp_d       = 4'd0;
        for (int i = 0; i < KEEP_BYTES; i++) begin
          buf_d[i] = (i == 0) ? byte_q : 8'h00;
        end
      end else if (close_frame) begin
        receiving_d = 1'b0;
        idx_d       = '0;
        exp_d       = 4'd0;
      end else if (receiving_q) begin
        for (int i = 0; i < KEEP_BYTES; i++) begin
          if (idx_q == IDX_W'(i)) begin
            buf_d[i] = byte_q;
          end
        end
        idx_d = idx_next[IDX_W-1:0];
        if ((idx_q == IDX_W'(1)) && (byte_q == cfg_i.type_code)) begin
          exp_d = cfg_i.frame_length;
        end
        // A frame that fills the buffer without closing is dropped.
        if (idx_next >= CMP_W'(BUFFER_BYTES)) begin
          receiving_d = 1'b0;
          idx_d       = '0;
          exp_d       = 4'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      receiving_q <= 1'b0;
      idx_q       <= '0;
      exp_q       <= 4'd0;
    end else begin
      in_valid_q  <= in_valid_d;
      receiving_q <= receiving_d;
      idx_q       <= idx_d;
      exp_q       <= exp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= rx_byte_i;
    end
    for (int i = 0; i < KEEP_BYTES; i++) begin
      buf_q[i] <= buf_d[i];
    end
  end

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(idx_q) < CMP_W'(BUFFER_BYTES))
    else $error("frame byte position reached the buffer size");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !receiving_q |-> (idx_q == '0) && (exp_q == 4'd0))
    else $error("idle parser holds a stale position or length");

  a_len_after_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (receiving_q && (exp_q != 4'd0)) |-> (CMP_W'(idx_q) >= CMP_W'(2)))
    else $error("frame length latched before the type byte");

  a_idle_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_ready_i) |=> !receiving_q)
    else $error("parser still receiving after a frame was emitted");

endmodule
`default_nettype wire

// ===== rtl/fsbp_out_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsbp_out_reg
// Result register that holds a decoded frame until the consumer takes it.
// ----------------------------------------------------------------------------
module fsbp_out_reg
  import fsbp_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    res_valid_i,
  output      logic    res_ready_o,
  input  wire result_t res_i,
  output      logic    out_valid_o,
  input  wire logic    out_ready_i,
  output      result_t out_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  assign res_ready_o = !valid_q || out_ready_i;
  assign valid_d     = res_valid_i || (valid_q && !out_ready_i);
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && res_ready_o) begin
      data_q <= res_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/framed_status_byte_parser_unit.sv =====
// A closing byte sits in the input register, its result then in the result register.
// Throughput: one byte per cycle, but a closing byte waits while the result register
// is full; bytes that yield no result pass even while a finished result waits at
// the output.
// Reset: asynchronous, active low; clears the parser state and loads the
// default configuration. The frame buffer is cleared at each frame start.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// framed_status_byte_parser_unit
// Assembles framed status messages from received bytes and decodes the fields.
// ----------------------------------------------------------------------------
module framed_status_byte_parser_unit
  import fsbp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output      logic       cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output      logic       in_ready_o,
  input  wire logic [7:0] rx_byte_i,
  output      logic       out_valid_o,
  input  wire logic       out_ready_i,
  output      logic [7:0] direction_o,
  output      logic [7:0] gear_o,
  output      logic       control_taken_o,
  output      logic       interior_light_o,
  output      logic       navigation_light_o,
  output      logic       battery_one_on_o,
  output      logic       battery_two_on_o,
  output      logic [7:0] battery_level_o
);

  cfg_t    cfg;
  logic    res_valid, res_ready;
  result_t res, out;

  fsbp_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  fsbp_frame_core u_frame_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  fsbp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out)
  );

  assign direction_o        = out.direction;
  assign gear_o             = out.gear;
  assign control_taken_o    = out.flags[0];
  assign interior_light_o   = out.flags[1];
  assign navigation_light_o = out.flags[2];
  assign battery_one_on_o   = out.flags[3];
  assign battery_two_on_o   = out.flags[4];
  assign battery_level_o    = out.battery_level;

endmodule
`default_nettype wire

// ===== tb/fsbp_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsbp_frame_checker
// Watches the configuration, byte and result channels of the status byte
// parser, tracks the frame assembly on its own and compares every decoded
// frame against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module fsbp_frame_checker
  import fsbp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [7:0]        direction_i,
  input  logic [7:0]        gear_i,
  input  logic              control_taken_i,
  input  logic              interior_light_i,
  input  logic              navigation_light_i,
  input  logic              battery_one_on_i,
  input  logic              battery_two_on_i,
  input  logic [7:0]        battery_level_i,
  output int unsigned       mismatches_o,
  output int unsigned       pending_o,
  output int unsigned       frames_o
);

  logic [7:0]  start_q;
  logic [7:0]  end_q;
  logic [7:0]  type_q;
  logic [3:0]  len_q;

  logic        in_frame;
  int unsigned pos;
  logic [3:0]  want_len;
  logic [7:0]  frame_bytes [BUFFER_BYTES];

  result_t     decoded_q [$];
  int unsigned mismatch_cnt;
  int unsigned frame_cnt;

  function automatic logic [7:0] byte_at(input int unsigned p);
    if (p < BUFFER_BYTES) return frame_bytes[p];
    return 8'h00;
  endfunction

  task automatic clear_frame();
    in_frame = 1'b0;
    pos      = 0;
    want_len = '0;
    foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
  endtask

  task automatic report(input string msg);
    mismatch_cnt++;
    $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  task automatic compare_field(input string field, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want)
      report($sformatf("%s: got 0x%02h, expected 0x%02h", field, got, want));
  endtask

  task automatic parse_byte(input logic [7:0] b);
    result_t    r;
    logic [7:0] flag_byte;
    if (!in_frame && b == start_q) begin
      clear_frame();
      in_frame = 1'b1;
    end else if (in_frame && b == end_q && pos + 1 == want_len) begin
      // The end byte is stored first, so a short frame can read it as a field.
      if (pos < BUFFER_BYTES) frame_bytes[pos] = b;
      flag_byte       = byte_at(4);
      r.direction     = byte_at(2);
      r.gear          = byte_at(3);
      r.flags         = flag_byte[4:0];
      r.battery_level = byte_at(5);
      // A start byte or type code rewritten while the frame was open suppresses the result.
      if (byte_at(0) == start_q && byte_at(1) == type_q) decoded_q.push_back(r);
      clear_frame();
      return;
    end
    if (in_frame) begin
      if (pos < BUFFER_BYTES) frame_bytes[pos] = b;
      pos++;
      if (pos == 2 && byte_at(1) == type_q) want_len = len_q;
      if (pos >= BUFFER_BYTES) clear_frame();
    end
  endtask

  task automatic check_result();
    result_t want;
    if (decoded_q.size() == 0) begin
      report($sformatf("result with nothing outstanding (direction 0x%02h)", direction_i));
      return;
    end
    want = decoded_q.pop_front();
    frame_cnt++;
    compare_field("direction", direction_i, want.direction);
    compare_field("gear", gear_i, want.gear);
    compare_field("control_taken", {7'b0, control_taken_i}, {7'b0, want.flags[0]});
    compare_field("interior_light", {7'b0, interior_light_i}, {7'b0, want.flags[1]});
    compare_field("navigation_light", {7'b0, navigation_light_i}, {7'b0, want.flags[2]});
    compare_field("battery_one_on", {7'b0, battery_one_on_i}, {7'b0, want.flags[3]});
    compare_field("battery_two_on", {7'b0, battery_two_on_i}, {7'b0, want.flags[4]});
    compare_field("battery_level", battery_level_i, want.battery_level);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q = START_BYTE_RST;
      end_q   = END_BYTE_RST;
      type_q  = TYPE_CODE_RST;
      len_q   = FRAME_LENGTH_RST;
      clear_frame();
      decoded_q.delete();
      mismatch_cnt = 0;
      frame_cnt    = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
      frames_o     <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_START_BYTE:   start_q = cfg_data_i;
          CFG_END_BYTE:     end_q   = cfg_data_i;
          CFG_TYPE_CODE:    type_q  = cfg_data_i;
          CFG_FRAME_LENGTH: len_q   = cfg_data_i[3:0];
          default:          ;
        endcase
      end
      if (out_valid_i && out_ready_i) check_result();
      if (in_valid_i && in_ready_i) parse_byte(rx_byte_i);
      mismatches_o <= mismatch_cnt;
      pending_o    <= decoded_q.size();
      frames_o     <= frame_cnt;
    end
  end

endmodule

// ===== tb/framed_status_byte_parser_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_status_byte_parser_unit_tb
// Feeds framed status traffic to the parser under a series of register
// settings: a directed opening with extreme fields, short frames, registers
// rewritten mid-frame and unknown frame types, then mostly well-formed random
// frames mixed with broken frames and line noise. Both channels idle at
// random; a separate checker predicts and compares the decoded frames.
// ----------------------------------------------------------------------------
module framed_status_byte_parser_unit_tb;
  import fsbp_pkg::*;

  localparam int unsigned STALL_LIMIT = 200;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_BYTES = 110;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  direction;
  logic [7:0]  gear;
  logic        control_taken;
  logic        interior_light;
  logic        navigation_light;
  logic        battery_one_on;
  logic        battery_two_on;
  logic [7:0]  battery_level;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned frames;

  // Register values as the stimulus side last wrote them.
  logic [7:0]  sh_start;
  logic [7:0]  sh_end;
  logic [7:0]  sh_type;
  logic [3:0]  sh_len;

  int unsigned bytes_sent;
  int unsigned quiet_cycles;
  int unsigned out_hold;
  logic        idle_on;
  logic        took_result;

  always #10 clk = ~clk;

  framed_status_byte_parser_unit dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .rx_byte_i          (rx_byte),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .direction_o        (direction),
    .gear_o             (gear),
    .control_taken_o    (control_taken),
    .interior_light_o   (interior_light),
    .navigation_light_o (navigation_light),
    .battery_one_on_o   (battery_one_on),
    .battery_two_on_o   (battery_two_on),
    .battery_level_o    (battery_level)
  );

  fsbp_frame_checker checker_i (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_i        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_ready_i         (in_ready),
    .rx_byte_i          (rx_byte),
    .out_valid_i        (out_valid),
    .out_ready_i        (out_ready),
    .direction_i        (direction),
    .gear_i             (gear),
    .control_taken_i    (control_taken),
    .interior_light_i   (interior_light),
    .navigation_light_i (navigation_light),
    .battery_one_on_i   (battery_one_on),
    .battery_two_on_i   (battery_two_on),
    .battery_level_i    (battery_level),
    .mismatches_o       (mismatches),
    .pending_o          (pending),
    .frames_o           (frames)
  );

  // Result side: after each transaction the receiver may hold off at random when idling is on.
  always @(posedge clk) begin
    if (out_valid && out_ready) took_result = 1'b1;
  end

  always @(negedge clk) begin
    if (took_result) begin
      took_result = 1'b0;
      out_hold    = idle_on ? $urandom_range(0, 3) : 0;
    end
    if (out_hold > 0) begin
      out_hold--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles.", STALL_LIMIT);
        $display("framed_status_byte_parser_unit_tb: errors");
        $finish;
      end
    end
  end

  // Valid stays high after a transaction so that back-to-back bytes keep it asserted.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [7:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_START_BYTE:   sh_start = data;
      CFG_END_BYTE:     sh_end   = data;
      CFG_TYPE_CODE:    sh_type  = data;
      CFG_FRAME_LENGTH: sh_len   = data[3:0];
      default:          ;
    endcase
  endtask

  task automatic set_config(input logic [7:0] s, input logic [7:0] e,
                            input logic [7:0] t, input logic [3:0] l);
    write_reg(CFG_START_BYTE, s);
    write_reg(CFG_END_BYTE, e);
    write_reg(CFG_TYPE_CODE, t);
    write_reg(CFG_FRAME_LENGTH, {4'b0, l});
  endtask

  // Waits for every outstanding result, then lets the input pipeline settle,
  // since bytes that close nothing leave no result to wait for.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_data();
    case ($urandom_range(0, 9))
      0:       return sh_start;
      1:       return sh_end;
      2:       return sh_type;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly well-formed frames; the rest are unknown types that run until the
  // buffer fills, truncated frames and loose noise bytes.
  task automatic send_frame();
    logic [7:0]  seq [$];
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(0, 99);
    if (kind < 90) begin
      seq.push_back(sh_start);
      if (kind >= 70 && kind < 80) seq.push_back(sh_type ^ 8'($urandom_range(1, 255)));
      else seq.push_back(sh_type);
      for (int p = 2; p + 1 < sh_len; p++) seq.push_back(pick_data());
      seq.push_back(sh_end);
      if (kind >= 70 && kind < 80) begin
        repeat ($urandom_range(0, 8)) seq.push_back(pick_data());
      end
      if (kind >= 80) begin
        n = $urandom_range(1, seq.size() - 1);
        while (seq.size() > n) void'(seq.pop_back());
      end
    end else begin
      repeat ($urandom_range(1, 6)) seq.push_back(pick_data());
    end
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  initial begin
    int unsigned target;
    rst_n        = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    rx_byte      = '0;
    out_ready    = 1'b0;
    took_result  = 1'b0;
    out_hold     = 0;
    quiet_cycles = 0;
    bytes_sent   = 0;
    idle_on      = 1'b1;
    sh_start     = START_BYTE_RST;
    sh_end       = END_BYTE_RST;
    sh_type      = TYPE_CODE_RST;
    sh_len       = FRAME_LENGTH_RST;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Default registers: the end byte as direction and the start byte as gear
    // are plain data, flags byte all ones, battery level zero.
    send_byte(8'h21); send_byte(8'hC0); send_byte(8'h3B); send_byte(8'h21);
    send_byte(8'hFF); send_byte(8'h00); send_byte(8'h3B);

    // Short frame: the end byte lands in the gear field, later fields read zero.
    drain();
    write_reg(CFG_FRAME_LENGTH, 8'd4);
    send_byte(8'h21); send_byte(8'hC0); send_byte(8'h80); send_byte(8'h3B);

    // Type and length rewritten mid-frame: the latched length still closes the
    // frame, but the stale type code suppresses the result.
    send_byte(8'h21); send_byte(8'hC0);
    drain();
    write_reg(CFG_TYPE_CODE, 8'h5A);
    write_reg(CFG_FRAME_LENGTH, 8'd9);
    send_byte(8'h11); send_byte(8'h3B);

    // Unknown type: the frame never closes and is dropped once the buffer fills.
    send_byte(8'h21); send_byte(8'hC0); send_byte(8'h3B); send_byte(8'h21);
    send_byte(8'h5A); send_byte(8'hFF); send_byte(8'h00); send_byte(8'h3B);
    send_byte(8'h80); send_byte(8'h01); send_byte(8'h7F); send_byte(8'h3B);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        0:       set_config(8'h21, 8'h3B, 8'hC0, 4'd7);
        1:       set_config(8'h00, 8'hFF, 8'hFF, 4'd12);
        2:       set_config(8'hFF, 8'h00, 8'h00, 4'd3);
        3:       set_config(8'h21, 8'h3B, 8'hC0, 4'd2);
        4:       set_config(8'h7E, 8'h7E, 8'h81, 4'd5);
        5:       set_config(8'hA5, 8'h5A, 8'h3C, 4'd6);
        default: set_config(8'($urandom), 8'($urandom), 8'($urandom),
                            4'($urandom_range(3, 12)));
      endcase
      idle_on = (phase == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
      target  = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) send_frame();
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Sent %0d bytes under %0d register settings, with short, unknown-type,",
             bytes_sent, PHASES + 3);
    $display("overfull and broken frames; %0d decoded frames compared, %0d mismatches.",
             frames, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("framed_status_byte_parser_unit_tb: clean");
    end else begin
      $display("framed_status_byte_parser_unit_tb: errors");
    end
    $finish;
  end

endmodule

// ===== framed_status_byte_parser_unit.f =====
rtl/fsbp_pkg.sv
rtl/fsbp_cfg_regs.sv
rtl/fsbp_frame_core.sv
rtl/fsbp_out_reg.sv
rtl/framed_status_byte_parser_unit.sv
tb/fsbp_frame_checker.sv
tb/framed_status_byte_parser_unit_tb.sv
